@@ hdl/urldec_pkg.sv @@
// ----------------------------------------------------------------------------
// urldec_pkg
// Types, character constants and hex-digit helper for the URL percent decoder.
// ----------------------------------------------------------------------------
package urldec_pkg;

   localparam int BYTE_W = 8;
   localparam int NIB_W  = 4;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [NIB_W-1:0]  nibble_type;

   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_PCT  = 2'd1,
      MODE_NIB  = 2'd2
   } mode_type;

   localparam byte_type CHAR_PLUS  = 8'h2B;
   localparam byte_type CHAR_PCT   = 8'h25;
   localparam byte_type CHAR_SPACE = 8'h20;

   // Hex digit lookup: ok flag plus nibble value.
   typedef struct packed {
      logic       ok;
      nibble_type value;
   } hex_type;

   function automatic hex_type hex_decode(input byte_type c);
      hex_type    r;
      byte_type   d;
      r = '0;
      d = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
         r.ok = 1'b1;
         r.value = d[NIB_W-1:0];
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h57;
         r.ok = 1'b1;
         r.value = d[NIB_W-1:0];
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h37;
         r.ok = 1'b1;
         r.value = d[NIB_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ hdl/url_percent_decoder_core.sv @@
// ----------------------------------------------------------------------------
// url_percent_decoder_core
// Streaming URL percent decoder: one encoded byte in, at most one byte out.
// ----------------------------------------------------------------------------
// One request per cycle is accepted into the input register while req_stall
// is low. Its result then moves into the result register once that is free
// and drives the outputs from there. '+' turns into a space,
// "%hh" turns into the encoded byte, a decoded zero is dropped, and malformed
// escapes are dropped. A request with req_in_last set always yields a result
// with rsp_out_last set, possibly with rsp_out_valid low. Requests that yield
// nothing pass through without using the result register. While a finished
// result waits on rsp_stall, the input register still takes requests that
// yield nothing and holds the first one that yields a result.
module url_percent_decoder_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  urldec_pkg::byte_type  req_in_byte,
   input  logic                  req_in_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output urldec_pkg::byte_type  rsp_out_byte,
   output logic                  rsp_out_valid,
   output logic                  rsp_out_last
);
   import urldec_pkg::*;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   byte_type   s1_byte_ff, s1_byte_in;
   logic       s1_last_ff, s1_last_in;

   // decode state
   mode_type   mode_ff, mode_in;
   nibble_type nib_ff, nib_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   byte_type   out_byte_ff, out_byte_in;
   logic       out_flag_ff, out_flag_in;
   logic       out_last_ff, out_last_in;

   hex_type    hex;
   mode_type   dec_mode;
   nibble_type dec_nib;
   byte_type   emit;
   logic       emit_ok;
   logic       has_result;
   logic       out_free;
   logic       s1_advance;
   logic       s1_fire;
   logic       req_fire;

   assign hex = hex_decode(s1_byte_ff);

   // next decode state for the byte held in the input register
   always_comb begin
      dec_mode = MODE_TEXT;
      dec_nib  = nib_ff;
      case (mode_ff)
         MODE_PCT: begin
            if (hex.ok) begin
               dec_nib  = hex.value;
               dec_mode = MODE_NIB;
            end
         end
         MODE_NIB: begin
            if (!hex.ok && s1_byte_ff == CHAR_PCT) begin
               dec_mode = MODE_PCT;
            end
         end
         default: begin
            if (s1_byte_ff == CHAR_PCT) begin
               dec_mode = MODE_PCT;
            end
         end
      endcase
      // end of string drops any pending escape
      if (s1_last_ff) begin
         dec_mode = MODE_TEXT;
         dec_nib  = '0;
      end
   end

   // byte produced by the byte held in the input register
   always_comb begin
      emit = '0;
      case (mode_ff)
         MODE_PCT: begin
            emit = '0;
         end
         MODE_NIB: begin
            if (hex.ok) begin
               emit = {nib_ff, hex.value};
            end else if (s1_byte_ff != CHAR_PCT) begin
               emit = (s1_byte_ff == CHAR_PLUS) ? CHAR_SPACE : s1_byte_ff;
            end
         end
         default: begin
            if (s1_byte_ff != CHAR_PCT) begin
               emit = (s1_byte_ff == CHAR_PLUS) ? CHAR_SPACE : s1_byte_ff;
            end
         end
      endcase
      emit_ok = (emit != '0);
   end

   // handshake and next values
   always_comb begin
      has_result = emit_ok || s1_last_ff;
      out_free   = !out_valid_ff || !rsp_stall;
      s1_advance = !has_result || out_free;
      s1_fire    = s1_valid_ff && s1_advance;
      req_stall  = s1_valid_ff && !s1_advance;
      req_fire   = req_valid && !req_stall;

      s1_valid_in = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      s1_byte_in  = req_fire ? req_in_byte : s1_byte_ff;
      s1_last_in  = req_fire ? req_in_last : s1_last_ff;

      mode_in = s1_fire ? dec_mode : mode_ff;
      nib_in  = s1_fire ? dec_nib : nib_ff;

      out_valid_in = out_valid_ff && rsp_stall;
      out_byte_in  = out_byte_ff;
      out_flag_in  = out_flag_ff;
      out_last_in  = out_last_ff;
      if (s1_fire && has_result) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_ok ? emit : '0;
         out_flag_in  = emit_ok;
         out_last_in  = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         mode_ff      <= MODE_TEXT;
         nib_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         mode_ff      <= mode_in;
         nib_ff       <= nib_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff  <= s1_byte_in;
      s1_last_ff  <= s1_last_in;
      out_byte_ff <= out_byte_in;
      out_flag_ff <= out_flag_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_out_valid = out_flag_ff;
   assign rsp_out_last  = out_last_ff;

endmodule

@@ tb/sv/url_percent_decoder_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_core_test
// Self-checking bench for the streaming URL percent decoder. Strings are fed
// one byte per request: first directed plain text, escapes and malformed cases,
// then random well-formed and broken strings. Each accepted request runs
// through a behavioral decoder, and every decoded result is compared in order
// against it, with random idling on both channels and one long output hold.
// ----------------------------------------------------------------------------
module url_percent_decoder_core_test;
   import urldec_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int LONG_HOLD      = 60;

   typedef struct packed {
      byte_type data;
      logic     valid;
      logic     last;
   } decoded_char_type;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_stall;
   byte_type req_in_byte;
   logic     req_in_last;
   logic     rsp_valid;
   logic     rsp_stall;
   byte_type rsp_out_byte;
   logic     rsp_out_valid;
   logic     rsp_out_last;

   decoded_char_type decoded_q[$];
   byte_type      text_q[$];
   mode_type      dec_mode   = MODE_TEXT;
   nibble_type    dec_nibble = '0;
   int            mismatch_count = 0;
   bit            sender_idle_on = 1'b1;
   bit            receiver_idle_on = 1'b1;
   int            hold_request_len = 0;

   url_percent_decoder_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_in_last   (req_in_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_last  (rsp_out_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // Decoder prediction
   // --------------------------------------------------------------------------
   function automatic bit hex_digit(input byte_type c, output nibble_type v);
      byte_type d;
      d = '0;
      hex_digit = 1'b1;
      if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
      else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h41 + 8'd10;
      else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h61 + 8'd10;
      else hex_digit = 1'b0;
      v = d[3:0];
   endfunction

   // Ordinary character: '%' opens an escape, '+' maps to space, NUL is dropped.
   function automatic void plain_char(input byte_type c, output byte_type emit,
                                      output logic emitted);
      emit = '0;
      emitted = 1'b0;
      if (c == CHAR_PCT) begin
         dec_mode = MODE_PCT;
      end else begin
         dec_mode = MODE_TEXT;
         emit = (c == CHAR_PLUS) ? CHAR_SPACE : c;
         emitted = (emit != 8'h00);
      end
   endfunction

   function automatic void decode_request(input byte_type c, input logic last);
      nibble_type    v;
      bit            is_hex;
      byte_type      emit;
      logic          emitted;
      decoded_char_type r;
      emit = '0;
      emitted = 1'b0;
      is_hex = hex_digit(c, v);
      case (dec_mode)
         MODE_PCT: begin
            if (is_hex) begin
               dec_nibble = v;
               dec_mode = MODE_NIB;
            end else begin
               dec_mode = MODE_TEXT;
            end
         end
         MODE_NIB: begin
            if (is_hex) begin
               emit = {dec_nibble, v};
               emitted = (emit != 8'h00);
               dec_mode = MODE_TEXT;
            end else begin
               plain_char(c, emit, emitted);
            end
         end
         default: plain_char(c, emit, emitted);
      endcase
      if (last) begin
         dec_mode = MODE_TEXT;
         dec_nibble = '0;
      end
      if (emitted || last) begin
         r.data  = emitted ? emit : 8'h00;
         r.valid = emitted;
         r.last  = last;
         decoded_q.push_back(r);
      end
   endfunction

   function automatic void report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("MISMATCH @%0t: %s", $time, msg);
   endfunction

   // Predict on accepted requests, check accepted results against the oldest.
   always @(posedge clock) begin
      decoded_char_type exp_char;
      if (!reset) begin
         if (req_valid && !req_stall) decode_request(req_in_byte, req_in_last);
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result byte=%02h valid=%b last=%b",
                                         rsp_out_byte, rsp_out_valid, rsp_out_last));
            end else begin
               exp_char = decoded_q.pop_front();
               if (rsp_out_byte !== exp_char.data || rsp_out_valid !== exp_char.valid ||
                   rsp_out_last !== exp_char.last)
                  report_mismatch($sformatf(
                     "expected byte=%02h valid=%b last=%b, got byte=%02h valid=%b last=%b",
                     exp_char.data, exp_char.valid, exp_char.last,
                     rsp_out_byte, rsp_out_valid, rsp_out_last));
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Result channel stall generator
   // --------------------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request_len > 0) begin
            stall_left = hold_request_len;
            hold_request_len = 0;
         end else if (stall_left == 0 && receiver_idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 15);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // End the run if neither channel moves for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Request driving
   // --------------------------------------------------------------------------
   task automatic send_request(input byte_type c, input logic last);
      if (sender_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= c;
      req_in_last <= last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_request(byte_type'(s[i]), i == s.len() - 1);
   endtask

   function automatic byte_type hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return byte_type'(8'h30 + v);
      if ($urandom_range(0, 1) == 0) return byte_type'(8'h41 + v - 10);
      return byte_type'(8'h61 + v - 10);
   endfunction

   function automatic byte_type non_hex_char();
      byte_type   c;
      nibble_type v;
      do c = byte_type'($urandom_range(1, 255)); while (hex_digit(c, v));
      return c;
   endfunction

   // Mostly well-formed strings with random content, some broken escapes.
   task automatic send_random_strings(input int item_goal);
      int sent;
      int pick;
      sent = 0;
      while (sent < item_goal) begin
         text_q.delete();
         repeat ($urandom_range(1, 8)) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               text_q.push_back(byte_type'($urandom_range(1, 255)));
            end else if (pick < 50) begin
               text_q.push_back(CHAR_PLUS);
            end else if (pick < 80) begin
               text_q.push_back(CHAR_PCT);
               text_q.push_back(hex_char());
               text_q.push_back(hex_char());
            end else if (pick < 88) begin
               text_q.push_back(CHAR_PCT);
               text_q.push_back(non_hex_char());
            end else if (pick < 96) begin
               text_q.push_back(CHAR_PCT);
               text_q.push_back(hex_char());
               text_q.push_back(non_hex_char());
            end else begin
               text_q.push_back(CHAR_PCT);
            end
         end
         foreach (text_q[i]) send_request(text_q[i], i == text_q.size() - 1);
         sent += text_q.size();
      end
   endtask

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------
   task automatic test_plain_text();
      send_request(8'h01, 1'b0);
      send_request(8'hFF, 1'b0);
      send_text("+");
   endtask

   task automatic test_escapes();
      send_text("%41%eF");
   endtask

   // Decoded zero, non-hex first digit, non-hex second digit ('%' and '+').
   task automatic test_malformed_escapes();
      send_text("%00%Gx");
      send_text("%4%41%7+");
   endtask

   task automatic test_pending_escape_at_end();
      send_text("%a");
   endtask

   task automatic test_random_strings();
      send_random_strings(380);
   endtask

   // Hold the output long enough for the block to back up into its input.
   task automatic test_long_output_hold();
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      hold_request_len = LONG_HOLD;
      for (int i = 0; i < 24; i++)
         send_request(byte_type'($urandom_range(8'h67, 8'h7A)), i == 23);
   endtask

   task automatic test_random_no_idle();
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      send_random_strings(80);
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_in_byte <= 8'h00;
      req_in_last <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_plain_text();
      test_escapes();
      test_malformed_escapes();
      test_pending_escape_at_end();
      test_random_strings();
      test_long_output_hold();
      test_random_no_idle();
      req_valid <= 1'b0;

      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (decoded_q.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", decoded_q.size()));
      if (mismatch_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

@@ url_percent_decoder_core.f @@
hdl/urldec_pkg.sv
hdl/url_percent_decoder_core.sv
tb/sv/url_percent_decoder_core_test.sv
